FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/cne_pkg.sv
// Package with shared constants, commands and controller/datapath types.
`default_nettype none
package cne_pkg;
  localparam int unsigned MaxAtomsDef  = 64;
  localparam int unsigned MaxShiftsDef = 27;
  localparam int unsigned CoordW = 24;
  localparam int unsigned RadW   = 12;
  localparam int unsigned CntW   = 11;
  localparam int unsigned GcnW   = 24;
  localparam int unsigned BulkW  = 19;
  localparam int unsigned CfgW   = 19;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DiffW  = 26;
  localparam int unsigned DistW  = 53;
  localparam int unsigned SumW   = 24;
  localparam int unsigned NumW   = 40;

  localparam logic [1:0] CmdLoadAtom  = 2'd0;
  localparam logic [1:0] CmdLoadShift = 2'd1;
  localparam logic [1:0] CmdCompute   = 2'd2;

  localparam logic [CfgIdxW-1:0] RegMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFixed = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTol   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBulk  = 2'd3;

  localparam logic [DistW-1:0] FloorSq = DistW'(167773);
  localparam logic [CntW-1:0]  CountSat = '1;
  localparam logic [GcnW-1:0]  GcnSat = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_atom;
    logic load_shift;
    logic pass2;      // 0 counting pass, 1 summing pass
    logic pair_go;    // issue the pair (i,j,s) into the pipeline
    logic acc_clear;  // clear per-atom accumulator
    logic acc_store;  // store count (pass 1) or latch stored count for output (pass 2)
    logic max_clear;
    logic bulk_latch;
    logic div_start;
  } cne_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_busy;
  } cne_sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/coordination_number_engine_core.sv
// Top level of the coordination number engine.
// Load transfers can follow back to back; a compute transfer runs two passes over
// all atom pairs and translations, one pair per cycle through a 4-stage
// pipeline, plus a 40-step divide per result.
// Results leave through an output register that holds while out_stall is high.
// Reset clears load counts and the controller; stores are undefined until loaded.
`default_nettype none
module coordination_number_engine_core
  import cne_pkg::*;
#(
  parameter int unsigned MAX_ATOMS  = MaxAtomsDef,
  parameter int unsigned MAX_SHIFTS = MaxShiftsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]   cfg_data_i,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        command_i,
  input  wire logic [CoordW-1:0] pos_x_i,
  input  wire logic [CoordW-1:0] pos_y_i,
  input  wire logic [CoordW-1:0] pos_z_i,
  input  wire logic [RadW-1:0]   radius_i,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [5:0]             atom_index_o,
  output logic [CntW-1:0]        neighbor_count_o,
  output logic [GcnW-1:0]        gcn_q8_o,
  output logic [BulkW-1:0]       bulk_used_q8_o,
  output logic                   last_o
);
  localparam int unsigned AIW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned SIW = (MAX_SHIFTS > 1) ? $clog2(MAX_SHIFTS) : 1;

  logic             mode_q;
  logic [15:0]      fixed_q, tol_q;
  logic [BulkW-1:0] bulk_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; fixed_q <= 16'd3072; tol_q <= 16'd307; bulk_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMode:  mode_q  <= cfg_data_i[0];
        RegFixed: fixed_q <= cfg_data_i[15:0];
        RegTol:   tol_q   <= cfg_data_i[15:0];
        RegBulk:  bulk_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cne_cmd_t cmd;
  cne_sts_t sts;
  logic [AIW-1:0] idx_i, idx_j, wr_atom, aidx;
  logic [SIW-1:0] idx_s, wr_shift;

  cne_controller #(.MAX_ATOMS(MAX_ATOMS), .MAX_SHIFTS(MAX_SHIFTS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .command_i, .out_valid, .out_stall,
    .cmd_o(cmd), .sts_i(sts), .idx_i_o(idx_i), .idx_j_o(idx_j), .idx_s_o(idx_s),
    .wr_atom_o(wr_atom), .wr_shift_o(wr_shift), .atom_index_o(aidx), .last_o
  );

  cne_datapath #(.MAX_ATOMS(MAX_ATOMS), .MAX_SHIFTS(MAX_SHIFTS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .idx_i_i(idx_i), .idx_j_i(idx_j),
    .idx_s_i(idx_s), .wr_atom_i(wr_atom), .wr_shift_i(wr_shift),
    .pos_x_i, .pos_y_i, .pos_z_i, .radius_i, .cutoff_mode_i(mode_q),
    .fixed_cutoff_i(fixed_q), .tolerance_i(tol_q), .bulk_coordination_i(bulk_q),
    .count_o(neighbor_count_o), .gcn_o(gcn_q8_o), .bulk_o(bulk_used_q8_o)
  );

  assign atom_index_o = 6'(aidx);
endmodule
`default_nettype wire

FILE: rtl/core/cne_divider.sv
// Restoring divider, one quotient bit per cycle, saturating quotient.
`default_nettype none
module cne_divider
  import cne_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NumW-1:0]  num_i,
  input  wire logic [BulkW-1:0] den_i,
  output logic                  busy_o,
  output logic [GcnW-1:0]       quot_o
);
  localparam int unsigned StepW = $clog2(NumW + 1);
  logic [StepW-1:0] step_q;
  logic [NumW-1:0]  num_q;
  logic [BulkW:0]   rem_q;
  logic [BulkW-1:0] den_q;
  logic [BulkW:0]   trial;

  assign trial = {rem_q[BulkW-1:0], num_q[NumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= StepW'(NumW);
    end else if (step_q != '0) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (step_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        num_q <= {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        num_q <= {num_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = (step_q != '0);
  // After NumW steps num_q holds the quotient.
  always_comb begin
    if (den_q == '0) begin
      quot_o = '0;
    end else if (num_q[NumW-1:GcnW] != '0) begin
      quot_o = GcnSat;
    end else begin
      quot_o = num_q[GcnW-1:0];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/cne_datapath.sv
// Datapath: atom, shift and count stores, pair test pipeline, accumulators.
`default_nettype none
module cne_datapath
  import cne_pkg::*;
#(
  parameter int unsigned MAX_ATOMS  = MaxAtomsDef,
  parameter int unsigned MAX_SHIFTS = MaxShiftsDef,
  parameter int unsigned AIW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
  parameter int unsigned SIW = (MAX_SHIFTS > 1) ? $clog2(MAX_SHIFTS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cne_cmd_t          cmd_i,
  output cne_sts_t               sts_o,
  input  wire logic [AIW-1:0]    idx_i_i,
  input  wire logic [AIW-1:0]    idx_j_i,
  input  wire logic [SIW-1:0]    idx_s_i,
  input  wire logic [AIW-1:0]    wr_atom_i,
  input  wire logic [SIW-1:0]    wr_shift_i,
  input  wire logic [CoordW-1:0] pos_x_i,
  input  wire logic [CoordW-1:0] pos_y_i,
  input  wire logic [CoordW-1:0] pos_z_i,
  input  wire logic [RadW-1:0]   radius_i,
  input  wire logic              cutoff_mode_i,
  input  wire logic [15:0]       fixed_cutoff_i,
  input  wire logic [15:0]       tolerance_i,
  input  wire logic [BulkW-1:0]  bulk_coordination_i,
  output logic [CntW-1:0]        count_o,
  output logic [GcnW-1:0]        gcn_o,
  output logic [BulkW-1:0]       bulk_o
);
  logic [CoordW-1:0] ax_mem [MAX_ATOMS];
  logic [CoordW-1:0] ay_mem [MAX_ATOMS];
  logic [CoordW-1:0] az_mem [MAX_ATOMS];
  logic [RadW-1:0]   ar_mem [MAX_ATOMS];
  logic [CoordW-1:0] sx_mem [MAX_SHIFTS];
  logic [CoordW-1:0] sy_mem [MAX_SHIFTS];
  logic [CoordW-1:0] sz_mem [MAX_SHIFTS];
  logic [CntW-1:0]   cnt_mem [MAX_ATOMS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_atom) begin
      ax_mem[wr_atom_i] <= pos_x_i;
      ay_mem[wr_atom_i] <= pos_y_i;
      az_mem[wr_atom_i] <= pos_z_i;
      ar_mem[wr_atom_i] <= radius_i;
    end
    if (cmd_i.load_shift) begin
      sx_mem[wr_shift_i] <= pos_x_i;
      sy_mem[wr_shift_i] <= pos_y_i;
      sz_mem[wr_shift_i] <= pos_z_i;
    end
  end

  // Stage 1: registered reads of atom i, atom j, shift s.
  logic [CoordW-1:0] ix_q, iy_q, iz_q, jx_q, jy_q, jz_q, tx_q, ty_q, tz_q;
  logic [RadW-1:0]   ir_q, jr_q;
  logic [CntW-1:0]   jc_q;
  logic              self_q;
  logic [3:0]        vld_q;
  always_ff @(posedge clk_i) begin
    ix_q <= ax_mem[idx_i_i];  iy_q <= ay_mem[idx_i_i];  iz_q <= az_mem[idx_i_i];
    ir_q <= ar_mem[idx_i_i];
    jx_q <= ax_mem[idx_j_i];  jy_q <= ay_mem[idx_j_i];  jz_q <= az_mem[idx_j_i];
    jr_q <= ar_mem[idx_j_i];
    jc_q <= cnt_mem[idx_j_i];
    tx_q <= sx_mem[idx_s_i];  ty_q <= sy_mem[idx_s_i];  tz_q <= sz_mem[idx_s_i];
    self_q <= (idx_i_i == idx_j_i);
  end

  // Stage 2: differences and covalent product.
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q;
  logic [29:0] p_q;
  logic        self2_q;
  logic [CntW-1:0] jc2_q;
  always_ff @(posedge clk_i) begin
    dx_q <= DiffW'($signed(jx_q)) - DiffW'($signed(ix_q)) + DiffW'($signed(tx_q));
    dy_q <= DiffW'($signed(jy_q)) - DiffW'($signed(iy_q)) + DiffW'($signed(ty_q));
    dz_q <= DiffW'($signed(jz_q)) - DiffW'($signed(iz_q)) + DiffW'($signed(tz_q));
    p_q  <= 30'(tolerance_i) * 30'({1'b0, ir_q} + {1'b0, jr_q});
    self2_q <= self_q && (tx_q == '0) && (ty_q == '0) && (tz_q == '0);
    jc2_q <= jc_q;
  end

  // Stage 3: squares and limit.
  logic [51:0] sqx_q, sqy_q, sqz_q;
  logic [DistW-1:0] lim_q;
  logic self3_q;
  logic [CntW-1:0] jc3_q;
  logic [59:0] pp;
  assign pp = 60'(p_q) * 60'(p_q);
  always_ff @(posedge clk_i) begin
    sqx_q <= $unsigned(52'(dx_q) * 52'(dx_q));
    sqy_q <= $unsigned(52'(dy_q) * 52'(dy_q));
    sqz_q <= $unsigned(52'(dz_q) * 52'(dz_q));
    if (cutoff_mode_i) begin
      lim_q <= DistW'((pp + 60'd65535) >> 16);
    end else begin
      lim_q <= DistW'(32'(fixed_cutoff_i) * 32'(fixed_cutoff_i));
    end
    self3_q <= self2_q;
    jc3_q <= jc2_q;
  end

  // Stage 4: sum and compare.
  logic hit_q;
  logic [CntW-1:0] jc4_q;
  logic [DistW-1:0] d;
  assign d = DistW'(sqx_q) + DistW'(sqy_q) + DistW'(sqz_q);
  always_ff @(posedge clk_i) begin
    hit_q <= !self3_q && (d < lim_q) && (d >= FloorSq);
    jc4_q <= jc3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], cmd_i.pair_go};
    end
  end

  // Accumulators.
  logic [CntW-1:0]  acc_q;
  logic [SumW-1:0]  sum_q;
  logic [CntW-1:0]  max_q;
  logic [BulkW-1:0] bulk_q;
  logic [CntW-1:0]  cnt_out_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clear) begin
      acc_q <= '0;
      sum_q <= '0;
    end else if (vld_q[3] && hit_q) begin
      if (acc_q != CountSat) acc_q <= acc_q + 1'b1;
      sum_q <= sum_q + SumW'(jc4_q);
    end
    if (cmd_i.max_clear) begin
      max_q <= '0;
    end else if (cmd_i.acc_store && !cmd_i.pass2 && acc_q > max_q) begin
      max_q <= acc_q;
    end
    if (cmd_i.acc_store && !cmd_i.pass2) begin
      cnt_mem[idx_i_i] <= acc_q;
    end
    if (cmd_i.acc_store && cmd_i.pass2) begin
      cnt_out_q <= cnt_mem[idx_i_i];
    end
    if (cmd_i.bulk_latch) begin
      bulk_q <= (bulk_coordination_i != '0) ? bulk_coordination_i
                                            : BulkW'({max_q, 8'd0});
    end
  end

  logic div_busy;
  cne_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (NumW'({sum_q, 16'd0})),
    .den_i   (bulk_q),
    .busy_o  (div_busy),
    .quot_o  (gcn_o)
  );

  assign sts_o.pipe_busy = |vld_q;
  assign sts_o.div_busy  = div_busy;
  assign count_o = cnt_out_q;
  assign bulk_o  = bulk_q;
endmodule
`default_nettype wire

FILE: rtl/core/cne_controller.sv
// Controller: load counters, pair sweep sequencing and result handshake.
`default_nettype none
module cne_controller
  import cne_pkg::*;
#(
  parameter int unsigned MAX_ATOMS  = MaxAtomsDef,
  parameter int unsigned MAX_SHIFTS = MaxShiftsDef,
  parameter int unsigned AIW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
  parameter int unsigned SIW = (MAX_SHIFTS > 1) ? $clog2(MAX_SHIFTS) : 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     command_i,
  output logic                out_valid,
  input  wire logic           out_stall,
  output cne_cmd_t            cmd_o,
  input  wire cne_sts_t       sts_i,
  output logic [AIW-1:0]      idx_i_o,
  output logic [AIW-1:0]      idx_j_o,
  output logic [SIW-1:0]      idx_s_o,
  output logic [AIW-1:0]      wr_atom_o,
  output logic [SIW-1:0]      wr_shift_o,
  output logic [AIW-1:0]      atom_index_o,
  output logic                last_o
);
  localparam int unsigned ACW = $clog2(MAX_ATOMS + 1);
  localparam int unsigned SCW = $clog2(MAX_SHIFTS + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSweep = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StStore = 3'd3;
  localparam logic [2:0] StBulk  = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [ACW-1:0] na_q, na_d;
  logic [SCW-1:0] ns_q, ns_d;
  logic [AIW-1:0] i_q, i_d, j_q, j_d;
  logic [SIW-1:0] s_q, s_d;
  logic pass_q, pass_d;
  logic ovld_q, ovld_d;
  logic acc;
  logic last_i, last_j, last_s;

  assign in_stall = (state_q != StIdle) || ovld_q;
  assign acc = in_valid && !in_stall;
  assign last_i = (ACW'(i_q) + 1'b1 == na_q);
  assign last_j = (ACW'(j_q) + 1'b1 == na_q);
  assign last_s = (SCW'(s_q) + 1'b1 == ns_q);

  always_comb begin
    state_d = state_q; na_d = na_q; ns_d = ns_q;
    i_d = i_q; j_d = j_q; s_d = s_q; pass_d = pass_q; ovld_d = ovld_q;
    cmd_o = '0;
    cmd_o.pass2 = pass_q;
    if (ovld_q && !out_stall) ovld_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          if (command_i == CmdLoadAtom && na_q < ACW'(MAX_ATOMS)) begin
            cmd_o.load_atom = 1'b1;
            na_d = na_q + 1'b1;
          end else if (command_i == CmdLoadShift && ns_q < SCW'(MAX_SHIFTS)) begin
            cmd_o.load_shift = 1'b1;
            ns_d = ns_q + 1'b1;
          end else if (command_i == CmdCompute && na_q != '0) begin
            i_d = '0; j_d = '0; s_d = '0; pass_d = 1'b0;
            cmd_o.acc_clear = 1'b1;
            cmd_o.max_clear = 1'b1;
            state_d = (ns_q == '0) ? StDrain : StSweep;
          end
        end
      end
      StSweep: begin
        cmd_o.pair_go = 1'b1;
        if (last_s) begin
          s_d = '0;
          if (last_j) begin
            j_d = '0;
            state_d = StDrain;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      StDrain: begin
        if (!sts_i.pipe_busy) state_d = StStore;
      end
      StStore: begin
        cmd_o.acc_store = 1'b1;
        if (!pass_q) begin
          if (last_i) begin
            state_d = StBulk;
          end else begin
            i_d = i_q + 1'b1;
            cmd_o.acc_clear = 1'b1;
            state_d = (ns_q == '0) ? StDrain : StSweep;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end
      end
      StBulk: begin
        cmd_o.bulk_latch = 1'b1;
        cmd_o.acc_clear = 1'b1;
        pass_d = 1'b1;
        i_d = '0;
        state_d = (ns_q == '0) ? StDrain : StSweep;
      end
      StDiv: begin
        if (!sts_i.div_busy && !ovld_q) begin
          ovld_d = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ovld_q) begin
          if (last_i) begin
            state_d = StIdle;
          end else begin
            i_d = i_q + 1'b1;
            cmd_o.acc_clear = 1'b1;
            state_d = (ns_q == '0) ? StDrain : StSweep;
          end
        end else if (!out_stall && last_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; na_q <= '0; ns_q <= '0;
      i_q <= '0; j_q <= '0; s_q <= '0; pass_q <= 1'b0; ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; na_q <= na_d; ns_q <= ns_d;
      i_q <= i_d; j_q <= j_d; s_q <= s_d; pass_q <= pass_d; ovld_q <= ovld_d;
    end
  end

  assign idx_i_o = i_q;
  assign idx_j_o = j_q;
  assign idx_s_o = s_q;
  assign wr_atom_o  = AIW'(na_q);
  assign wr_shift_o = SIW'(ns_q);
  assign out_valid = ovld_q;
  assign atom_index_o = i_q;
  assign last_o = last_i;
endmodule
`default_nettype wire

FILE: rtl/core/cne_checker.sv
// Port-level checker for the coordination number engine, bound to the top.
`default_nettype none
`include "assert_macros.svh"
module cne_checker
  import cne_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire logic [5:0]      atom_index_o,
  input wire logic            last_o,
  input wire logic [BulkW-1:0] bulk_used_q8_o
);
  `ASSERT_IMPL(no_input_while_output, clk_i, rst_ni, out_valid, in_stall)
  `ASSERT_NEXT(out_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(atom_index_o))
  `ASSERT_NEXT(idle_after_last, clk_i, rst_ni, out_valid && !out_stall && last_o, !out_valid)
  `ASSERT_IMPL(bulk_steady, clk_i, rst_ni, out_valid && $past(out_valid), $stable(bulk_used_q8_o))
endmodule
bind coordination_number_engine_core cne_checker u_chk (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
  .atom_index_o, .last_o, .bulk_used_q8_o
);
`default_nettype wire
